FILE: rtl/dpw_pkg.sv
// Shared types, constants and helpers for the depth pixel to world point block.
// No dependencies; every other file but dpw_fifo refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package dpw_pkg;

    localparam logic REQ_POSE  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic [2:0] REG_INV_FOCAL_X = 3'd0;
    localparam logic [2:0] REG_INV_FOCAL_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_X    = 3'd2;
    localparam logic [2:0] REG_CENTER_Y    = 3'd3;
    localparam logic [2:0] REG_DEPTH_SCALE = 3'd4;
    localparam logic [2:0] REG_MIN_DEPTH   = 3'd5;
    localparam logic [2:0] REG_MAX_DEPTH   = 3'd6;

    localparam int POSE_ENTRIES = 12;
    localparam int WORK_DEPTH   = 4;
    localparam int OUT_DEPTH    = 2;

    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               req_type;
        logic [3:0]         pose_index;
        logic signed [31:0] pose_value;
        logic [9:0]         pixel_row;
        logic [10:0]        pixel_col;
        logic [15:0]        depth_raw;
        logic [7:0]         pixel_red;
        logic [7:0]         pixel_green;
        logic [7:0]         pixel_blue;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [7:0]         point_red;
        logic [7:0]         point_green;
        logic [7:0]         point_blue;
    } t_out_item;

    typedef struct packed {
        logic [31:0] inv_focal_x;
        logic [31:0] inv_focal_y;
        logic [26:0] center_x;
        logic [26:0] center_y;
        logic [31:0] depth_scale;
        logic [31:0] min_depth;
        logic [31:0] max_depth;
    } t_cfg;

    // Per-item data that rides alongside the arithmetic.
    typedef struct packed {
        logic               is_pose;
        logic [3:0]         pose_index;
        logic signed [31:0] pose_value;
        logic [31:0]        depth;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_side;

    // Item handed from the front to the back through the work queue.
    typedef struct packed {
        t_side              side;
        logic signed [27:0] diff_x;
        logic signed [27:0] diff_y;
    } t_work;

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v > 51'(SAT_MAX)) begin
            r = SAT_MAX;
        end else if (v < 51'(SAT_MIN)) begin
            r = SAT_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/dpw_fifo.sv
// Small register queue with count-based full and empty.
// Uses no package items; payload type is a module parameter.
`timescale 1ns / 1ps
`default_nettype none
module dpw_fifo #(
    parameter type T_DATA = logic,
    parameter int  DEPTH  = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire T_DATA i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output T_DATA      o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T_DATA          r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/dpw_front.sv
// Front end: takes input items, scales depth, drops rejected items, feeds the work queue.
// Depends on dpw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dpw_front #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 2048
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire dpw_pkg::t_cfg    i_cfg,
    input  wire logic             i_push,
    input  wire dpw_pkg::t_in_item i_item,
    output logic                  o_full,
    output logic                  o_q_push,
    output dpw_pkg::t_work        o_q_data,
    input  wire logic             i_q_full
);
    logic                r_valid;
    dpw_pkg::t_in_item   r_item;
    logic [47:0]         r_prod;
    logic signed [27:0]  r_dx, r_dy;
    logic                r_inside;

    logic [48:0] d_sum;
    logic [31:0] depth;
    logic        keep, free, load;

    assign d_sum = {1'b0, r_prod} + 49'd32768;
    assign depth = d_sum[47:16];

    always_comb begin
        if (r_item.req_type == dpw_pkg::REQ_POSE) begin
            keep = (32'(r_item.pose_index) < 32'(dpw_pkg::POSE_ENTRIES));
        end else begin
            keep = r_inside && (depth >= i_cfg.min_depth) && (depth <= i_cfg.max_depth);
        end
    end

    assign o_q_push = r_valid && keep && !i_q_full;
    assign free     = !r_valid || !keep || !i_q_full;
    assign o_full   = !free;
    assign load     = i_push && free;

    always_comb begin
        o_q_data.side.is_pose    = (r_item.req_type == dpw_pkg::REQ_POSE);
        o_q_data.side.pose_index = r_item.pose_index;
        o_q_data.side.pose_value = r_item.pose_value;
        o_q_data.side.depth      = depth;
        o_q_data.side.red        = r_item.pixel_red;
        o_q_data.side.green      = r_item.pixel_green;
        o_q_data.side.blue       = r_item.pixel_blue;
        o_q_data.diff_x          = r_dx;
        o_q_data.diff_y          = r_dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (free) begin
            r_valid <= load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item   <= i_item;
            r_prod   <= {32'b0, i_item.depth_raw} * {16'b0, i_cfg.depth_scale};
            r_dx     <= $signed({1'b0, i_item.pixel_col, 16'b0}) - $signed({1'b0, i_cfg.center_x});
            r_dy     <= $signed({2'b0, i_item.pixel_row, 16'b0}) - $signed({1'b0, i_cfg.center_y});
            r_inside <= (32'(i_item.pixel_row) < MAX_ROWS) && (32'(i_item.pixel_col) < MAX_COLS);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/dpw_back.sv
// Back end: six-stage pipeline for back-projection and pose transform; holds the pose.
// Depends on dpw_pkg. Pose writes take effect at the stage where the pose is read.
`timescale 1ns / 1ps
`default_nettype none
module dpw_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dpw_pkg::t_cfg   i_cfg,
    input  wire logic            i_q_empty,
    input  wire dpw_pkg::t_work  i_q_data,
    output logic                 o_q_pop,
    output logic                 o_r_push,
    output dpw_pkg::t_out_item   o_r_data,
    input  wire logic            i_r_full
);
    logic signed [31:0] r_pose [dpw_pkg::POSE_ENTRIES];

    logic [6:1]      r_v;
    dpw_pkg::t_side  r_s [6:1];

    logic signed [60:0] r_px, r_py;
    logic signed [28:0] r_nx, r_ny;
    logic signed [61:0] r_qx, r_qy;
    logic signed [31:0] r_cam [3];
    logic signed [63:0] r_prod [9];
    logic signed [31:0] r_tr3 [3], r_tr5 [3];
    logic signed [47:0] r_term [9];

    logic adv;
    logic signed [60:0] rx2, ry2;
    logic signed [61:0] rx4, ry4;
    logic signed [49:0] w [3];

    assign adv     = !(r_v[6] && !r_s[6].is_pose && i_r_full);
    assign o_q_pop = adv && !i_q_empty;

    // Round half away from zero: add half, less one when negative, then floor.
    assign rx2 = r_px + 61'sh8000_0000 - 61'(r_px[60]);
    assign ry2 = r_py + 61'sh8000_0000 - 61'(r_py[60]);
    assign rx4 = r_qx + 62'sh8000 - 62'(r_qx[61]);
    assign ry4 = r_qy + 62'sh8000 - 62'(r_qy[61]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            for (int i = 0; i < dpw_pkg::POSE_ENTRIES; i++) begin
                r_pose[i] <= (i == 0 || i == 5 || i == 10) ? dpw_pkg::ONE_Q16 : '0;
            end
        end else if (adv) begin
            r_v <= {r_v[5:1], o_q_pop};
            if (r_v[4] && r_s[4].is_pose) begin
                r_pose[r_s[4].pose_index] <= r_s[4].pose_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s[1] <= i_q_data.side;
            for (int k = 2; k <= 6; k++) begin
                r_s[k] <= r_s[k-1];
            end
            r_px <= i_q_data.diff_x * $signed({1'b0, i_cfg.inv_focal_x});
            r_py <= i_q_data.diff_y * $signed({1'b0, i_cfg.inv_focal_y});
            r_nx <= rx2[60:32];
            r_ny <= ry2[60:32];
            r_qx <= r_nx * $signed({1'b0, r_s[2].depth});
            r_qy <= r_ny * $signed({1'b0, r_s[2].depth});
            r_cam[0] <= dpw_pkg::sat32(51'(signed'(rx4[61:16])));
            r_cam[1] <= dpw_pkg::sat32(51'(signed'(ry4[61:16])));
            r_cam[2] <= dpw_pkg::sat32(51'(signed'({1'b0, r_s[3].depth})));
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r*3+c] <= r_pose[r*4+c] * r_cam[c];
                end
                r_tr5[r] <= r_pose[r*4+3];
                r_tr3[r] <= r_tr5[r];
            end
            for (int j = 0; j < 9; j++) begin
                r_term[j] <= 48'((r_prod[j] + 64'sh8000 - 64'(r_prod[j][63])) >>> 16);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w[r] = 50'(r_term[r*3]) + 50'(r_term[r*3+1]) + 50'(r_term[r*3+2])
                 + 50'(r_tr3[r]);
        end
        o_r_data.point_x     = dpw_pkg::sat32(51'(w[0]));
        o_r_data.point_y     = dpw_pkg::sat32(51'(w[2]));
        o_r_data.point_z     = dpw_pkg::sat32(-51'(w[1]));
        o_r_data.point_red   = r_s[6].red;
        o_r_data.point_green = r_s[6].green;
        o_r_data.point_blue  = r_s[6].blue;
    end

    assign o_r_push = r_v[6] && !r_s[6].is_pose && !i_r_full;
endmodule
`default_nettype wire

FILE: rtl/depth_pixel_to_world_point.sv
// Depth pixel to colored world point: an accepted item passes 1 front stage, the work
// queue, 6 back stages and the result queue before the point shows on the result ports;
// one item per cycle sustained while the result queue has room, set by the fully pipelined
// multipliers. Rejected pixels and pose items give no result.
// Reset (synchronous, active low) empties both queues, restores the camera registers
// to their defaults and the pose to identity rotation with zero translation.
`timescale 1ns / 1ps
`default_nettype none
module depth_pixel_to_world_point #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 2048
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               push,
    input  wire dpw_pkg::t_in_item  i_item,
    output logic                    full,
    output logic                    empty,
    input  wire logic               pop,
    output dpw_pkg::t_out_item      o_item
);
    dpw_pkg::t_cfg      r_cfg;
    logic               q_push, q_full, q_pop, q_empty;
    dpw_pkg::t_work     q_in, q_out;
    logic               r_push_w, r_full_w;
    dpw_pkg::t_out_item r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_focal_x <= 32'd8180898;
            r_cfg.inv_focal_y <= 32'd8180898;
            r_cfg.center_x    <= 27'd20938752;
            r_cfg.center_y    <= 27'd15695872;
            r_cfg.depth_scale <= 32'd858993;
            r_cfg.min_depth   <= 32'd655;
            r_cfg.max_depth   <= 32'd360448;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dpw_pkg::REG_INV_FOCAL_X: r_cfg.inv_focal_x <= i_cfg_data;
                dpw_pkg::REG_INV_FOCAL_Y: r_cfg.inv_focal_y <= i_cfg_data;
                dpw_pkg::REG_CENTER_X:    r_cfg.center_x    <= i_cfg_data[26:0];
                dpw_pkg::REG_CENTER_Y:    r_cfg.center_y    <= i_cfg_data[26:0];
                dpw_pkg::REG_DEPTH_SCALE: r_cfg.depth_scale <= i_cfg_data;
                dpw_pkg::REG_MIN_DEPTH:   r_cfg.min_depth   <= i_cfg_data;
                dpw_pkg::REG_MAX_DEPTH:   r_cfg.max_depth   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dpw_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_push(push), .i_item(i_item), .o_full(full),
        .o_q_push(q_push), .o_q_data(q_in), .i_q_full(q_full)
    );

    dpw_fifo #(.T_DATA(dpw_pkg::t_work), .DEPTH(dpw_pkg::WORK_DEPTH)) u_work_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(q_push), .i_data(q_in),
        .o_full(q_full), .i_pop(q_pop), .o_empty(q_empty), .o_data(q_out)
    );

    dpw_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_q_empty(q_empty), .i_q_data(q_out), .o_q_pop(q_pop),
        .o_r_push(r_push_w), .o_r_data(r_data), .i_r_full(r_full_w)
    );

    dpw_fifo #(.T_DATA(dpw_pkg::t_out_item), .DEPTH(dpw_pkg::OUT_DEPTH)) u_out_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(r_push_w), .i_data(r_data),
        .o_full(r_full_w), .i_pop(pop), .o_empty(empty), .o_data(o_item)
    );
endmodule
`default_nettype wire
